// ===== hw/rtl/rvtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvtq_pkg
// Types, codes and sizes shared by the remote variable transaction queue.
// ----------------------------------------------------------------------------
package rvtq_pkg;

  localparam int QDEPTH  = 8;
  localparam int PTR_W   = $clog2(QDEPTH);
  localparam int CNT_W   = $clog2(QDEPTH + 1);
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;

  // input modes
  localparam logic [2:0] MODE_OPEN  = 3'd0;
  localparam logic [2:0] MODE_CLOSE = 3'd1;
  localparam logic [2:0] MODE_SETR  = 3'd2;
  localparam logic [2:0] MODE_GETR  = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;

  // transaction states
  localparam logic [2:0] TS_INVALID = 3'd0;
  localparam logic [2:0] TS_SCHED   = 3'd1;
  localparam logic [2:0] TS_WAIT    = 3'd2;
  localparam logic [2:0] TS_RETRY   = 3'd3;
  localparam logic [2:0] TS_TIMEOUT = 3'd4;
  localparam logic [2:0] TS_TXERR   = 3'd5;
  localparam logic [2:0] TS_READY   = 3'd6;
  localparam logic [2:0] TS_ERROR   = 3'd7;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_RESEND   = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_LIMIT    = 2'd3;

  localparam logic [7:0]  RST_OWN_ADDR = 8'd0;
  localparam logic [15:0] RST_TIMEOUT  = 16'd100;
  localparam logic [15:0] RST_RESEND   = 16'd50;
  localparam logic [2:0]  RST_LIMIT    = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  dest_addr;
    logic [7:0]  var_index;
    logic        dir;
    logic [7:0]  length;
    logic [2:0]  slot;
    logic [15:0] now_ms;
    logic        bus_accepts;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  handle;
    logic [2:0]  txn_state;
    logic        send_valid;
    logic [7:0]  send_src;
    logic [7:0]  send_dest;
    logic        send_kind;
    logic [7:0]  send_index;
    logic [7:0]  send_length;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  index;
    logic [7:0]  length;
    logic        dir;
    logic [2:0]  status;
    logic [2:0]  retries;
    logic [15:0] stamp;
  } entry_t;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    next_pos = (32'(p) == QDEPTH - 1) ? '0 : PTR_W'(32'(p) + 1);
  endfunction

endpackage

// ===== hw/rtl/remote_var_transaction_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_var_transaction_queue
// Ring of remote get/set transaction descriptors held in one memory.
// ----------------------------------------------------------------------------
// Flow: open, spare modes, query of an unused slot and replies or ticks on an
//   empty ring go straight to the result; reply/tick read the head entry, then
//   modify and write back, query reads its slot; close skips the head, at most QDEPTH.
// One beat at a time: a new beat is taken only once its result is loaded;
//   a stalled output register holds off the next beat.
// Reset: synchronous, active low; pointers, valid bits cleared, config to defaults.
module remote_var_transaction_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rvtq_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rvtq_pkg::out_beat_t           out_data,
  input  logic                          cfg_we,
  input  logic [rvtq_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [rvtq_pkg::CFG_D_W-1:0]  cfg_wdata
);
  import rvtq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SKIP = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QDEPTH-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]  skip_cnt_r, skip_cnt_nxt;
  in_beat_t          req_r;
  out_beat_t         res_r, res_nxt;
  out_beat_t         out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [7:0]        own_addr_r;
  logic [15:0]       timeout_r, resend_r;
  logic [2:0]        limit_r;

  entry_t            mem [QDEPTH];
  entry_t            mem_rd_r;
  entry_t            mem_wd;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_wa, mem_ra;

  logic              in_fire;
  logic              empty;
  logic              in_slot_ok;
  logic [PTR_W-1:0]  in_slot_idx, req_slot_idx;
  logic [15:0]       elapsed;
  logic [2:0]        head_status;
  entry_t            e;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign empty       = (rp_r == wp_r);
  assign in_slot_ok  = (32'(in_data.slot) < QDEPTH);
  assign in_slot_idx = PTR_W'(in_data.slot);
  assign req_slot_idx = PTR_W'(req_r.slot);
  assign e           = mem_rd_r;
  assign elapsed     = req_r.now_ms - e.stamp;
  assign head_status = vld_r[rp_r] ? e.status : TS_INVALID;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    vld_nxt       = vld_r;
    skip_cnt_nxt  = skip_cnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = rp_r;
    mem_wd        = e;
    mem_ra        = rp_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_data.mode)
            MODE_OPEN: begin
              if (next_pos(wp_r) != rp_r) begin
                mem_we          = 1'b1;
                mem_wa          = wp_r;
                mem_wd.dest     = in_data.dest_addr;
                mem_wd.index    = in_data.var_index;
                mem_wd.length   = in_data.length;
                mem_wd.dir      = in_data.dir;
                mem_wd.status   = TS_SCHED;
                mem_wd.retries  = limit_r;
                mem_wd.stamp    = '0;
                vld_nxt[wp_r]   = 1'b1;
                wp_nxt          = next_pos(wp_r);
                res_nxt.ok        = 1'b1;
                res_nxt.handle    = 3'(wp_r);
                res_nxt.txn_state = TS_SCHED;
              end
            end
            MODE_CLOSE: begin
              if (in_slot_ok) begin
                vld_nxt[in_slot_idx] = 1'b0;
              end
              skip_cnt_nxt = '0;
              state_nxt    = S_SKIP;
            end
            MODE_SETR, MODE_GETR, MODE_TICK: begin
              if (!empty) begin
                state_nxt = S_MOD;
              end
            end
            MODE_QUERY: begin
              // invalid slots never hold a stored state, so skip the read
              if (in_slot_ok && vld_r[in_slot_idx]) begin
                mem_ra    = in_slot_idx;
                state_nxt = S_MOD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SKIP: begin
        if (32'(skip_cnt_r) == QDEPTH || empty || vld_r[rp_r]) begin
          state_nxt = S_DONE;
        end else begin
          rp_nxt       = next_pos(rp_r);
          skip_cnt_nxt = skip_cnt_r + 1'b1;
        end
      end
      S_MOD: begin
        state_nxt = S_DONE;
        case (req_r.mode)
          MODE_SETR: begin
            mem_we        = 1'b1;
            mem_wd.status = (req_r.var_index == e.index) ? TS_READY : TS_ERROR;
            vld_nxt[rp_r] = 1'b1;
          end
          MODE_GETR: begin
            mem_we        = 1'b1;
            mem_wd.status = (req_r.var_index == e.index && req_r.length == e.length)
                            ? TS_READY : TS_ERROR;
            vld_nxt[rp_r] = 1'b1;
          end
          MODE_TICK: begin
            case (head_status)
              TS_SCHED: begin
                res_nxt.send_valid = 1'b1;
                mem_we        = 1'b1;
                mem_wd.status = req_r.bus_accepts ? TS_WAIT : TS_RETRY;
                mem_wd.stamp  = req_r.now_ms;
              end
              TS_WAIT: begin
                if (elapsed > timeout_r) begin
                  mem_we        = 1'b1;
                  mem_wd.status = TS_TIMEOUT;
                end
              end
              TS_RETRY: begin
                if (elapsed > resend_r) begin
                  mem_we = 1'b1;
                  if (e.retries != 3'd0) begin
                    res_nxt.send_valid = 1'b1;
                    mem_wd.stamp       = req_r.now_ms;
                    if (req_r.bus_accepts) begin
                      mem_wd.status = TS_WAIT;
                    end else begin
                      mem_wd.status  = TS_RETRY;
                      mem_wd.retries = e.retries - 3'd1;
                    end
                  end else begin
                    mem_wd.status = TS_TXERR;
                  end
                end
              end
              default: begin
                mem_we = 1'b0;
              end
            endcase
            if (res_nxt.send_valid) begin
              res_nxt.send_src    = own_addr_r;
              res_nxt.send_dest   = e.dest;
              res_nxt.send_kind   = e.dir;
              res_nxt.send_index  = e.index;
              res_nxt.send_length = e.dir ? e.length : 8'd0;
            end
          end
          MODE_QUERY: begin
            res_nxt.txn_state = vld_r[req_slot_idx] ? e.status : TS_INVALID;
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      vld_r       <= '0;
      skip_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      own_addr_r  <= RST_OWN_ADDR;
      timeout_r   <= RST_TIMEOUT;
      resend_r    <= RST_RESEND;
      limit_r     <= RST_LIMIT;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      vld_r       <= vld_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_OWN_ADDR: own_addr_r <= cfg_wdata[7:0];
          CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
          CFG_RESEND:   resend_r   <= cfg_wdata;
          CFG_LIMIT:    limit_r    <= cfg_wdata[2:0];
          default:      own_addr_r <= own_addr_r;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // the modify step always directly follows the beat that issued the read
  a_mod_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOD |-> $past(in_fire))
    else $error("modify step without a preceding read");

  // an accepted open on a non-full ring advances the write pointer
  a_open_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == MODE_OPEN && next_pos(wp_r) != rp_r)
      |=> wp_r != $past(wp_r))
    else $error("open did not advance write pointer");

  // memory writes only on open accept or in the modify step
  a_mem_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_MOD || (in_fire && in_data.mode == MODE_OPEN)))
    else $error("stray memory write");

  // head skip is bounded by the ring depth
  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SKIP |-> 32'(skip_cnt_r) <= QDEPTH)
    else $error("head skip ran past ring depth");

  // a result is only loaded when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("result dropped while output busy");

endmodule
